### rtl/core/rlpp_pkg.sv
`default_nettype none

package rlpp_pkg;

  // Panel geometry
  localparam int DISPLAY_WIDTH  = 84;
  localparam int DISPLAY_HEIGHT = 48;
  localparam int FULL_PAGES     = DISPLAY_HEIGHT / 8;
  localparam int TAIL_ROWS      = DISPLAY_HEIGHT % 8;

  // Counter and address widths
  localparam int COL_W  = (DISPLAY_WIDTH > 1) ? $clog2(DISPLAY_WIDTH) : 1;
  localparam int PAGE_W = $clog2(FULL_PAGES + 1);
  localparam int ROW_W  = 3;
  localparam int BITS_W = 7;

  // Controller commands
  localparam logic [7:0] CMD_SET_X = 8'h80;
  localparam logic [7:0] CMD_SET_Y = 8'h40;

endpackage : rlpp_pkg

`default_nettype wire

### rtl/core/rlpp_if.sv
`default_nettype none

// Pixel stream channel
interface rlpp_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  logic        frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface : rlpp_pix_if

// Controller byte channel
interface rlpp_lcd_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       run_last;

  modport source (output valid, output out_byte, output is_data, output run_last, input ready);
  modport sink   (input valid, input out_byte, input is_data, input run_last, output ready);
endinterface : rlpp_lcd_if

`default_nettype wire

### rtl/core/raster_to_lcd_page_packer.sv
`default_nettype none

// Raster to page-mode packer for a monochrome LCD controller.
// pix: framebuffer pixels in raster order, DISPLAY_WIDTH per row; any nonzero
//   pixel_value is lit. frame_start on a pixel restarts at column 0, row 0,
//   page 0.
// lcd: command and data bytes. Rows 0 to 6 of a page give nothing and are
//   gathered in a per-column memory; each pixel of row 7 gives one data byte
//   (row k in bit k), and column 0 of row 7 first gives the commands 0x80 and
//   0x40 | page. run_last marks the final byte a pixel causes.
// A byte passes through the second stage and the output register to lcd.
// Throughput: one pixel per cycle while lcd is ready; at column 0 of row 7 the
//   pixel holds the second stage for its three bytes, as the single output
//   register sends one byte per cycle. The column memory is read on entry and
//   written on leaving the second stage; a write to the column read is forwarded.
// Stalls: while lcd is not ready the byte waits in the output register; pixels
//   that give no byte keep flowing, and the first one that needs the output
//   waits in the second stage, which then holds pix.ready low.
// Reset: counters clear, both stages empty. The column memory is not cleared:
//   row 0 rewrites each entry before it is read.
module raster_to_lcd_page_packer
  import rlpp_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  rlpp_pix_if.sink  pix,
  rlpp_lcd_if.source lcd
);

  // Position counters
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_in_page;
  logic [PAGE_W-1:0] page_count;

  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [PAGE_W-1:0] page_cur;
  logic [COL_W-1:0]  column_count_next;
  logic [ROW_W-1:0]  row_in_page_next;
  logic [PAGE_W-1:0] page_count_next;
  logic              in_page;
  logic              accept;

  // Second stage
  logic              s1_valid;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic [PAGE_W-1:0] s1_page;
  logic              s1_lit;
  logic              s1_emit;
  logic              s1_cmd;
  logic              s1_we;
  logic [1:0]        s1_idx;
  logic              fwd;
  logic [BITS_W-1:0] fwd_data;

  logic [BITS_W-1:0] rd_data;
  logic [BITS_W-1:0] base;
  logic [BITS_W-1:0] s1_wdata;
  logic [1:0]        last_idx;
  logic              out_free;
  logic              s1_move;
  logic              s1_done;
  logic [7:0]        res_byte;
  logic              res_data;
  logic              res_last;

  // Position of the incoming pixel and the one after it
  always_comb begin
    col_cur  = pix.frame_start ? '0 : column_count;
    row_cur  = pix.frame_start ? '0 : row_in_page;
    page_cur = pix.frame_start ? '0 : page_count;
    in_page  = (page_cur < PAGE_W'(FULL_PAGES));

    column_count_next = col_cur + COL_W'(1);
    row_in_page_next  = row_cur;
    page_count_next   = page_cur;
    if (col_cur == COL_W'(DISPLAY_WIDTH - 1)) begin
      column_count_next = '0;
      row_in_page_next  = row_cur + ROW_W'(1);
      if (in_page) begin
        if (row_cur == ROW_W'(7)) begin
          row_in_page_next = '0;
          page_count_next  = page_cur + PAGE_W'(1);
          if ((page_cur == PAGE_W'(FULL_PAGES - 1)) && (TAIL_ROWS == 0)) begin
            page_count_next = '0;
          end
        end
      end else if (({1'b0, row_cur} + 4'd1) >= 4'(TAIL_ROWS)) begin
        row_in_page_next = '0;
        page_count_next  = '0;
      end
    end
  end

  // Second stage control
  always_comb begin
    base     = fwd ? fwd_data : rd_data;
    s1_wdata = (s1_row == '0) ? BITS_W'(s1_lit) : (base | (BITS_W'(s1_lit) << s1_row));
    last_idx = s1_cmd ? 2'd2 : 2'd0;
    out_free = !lcd.valid || lcd.ready;
    s1_move  = s1_valid && s1_emit && out_free;
    s1_done  = s1_valid && (!s1_emit || (out_free && (s1_idx == last_idx)));
    accept   = pix.valid && pix.ready;

    res_byte = {s1_lit, base};
    res_data = 1'b1;
    res_last = 1'b1;
    if (s1_cmd && (s1_idx == 2'd0)) begin
      res_byte = CMD_SET_X;
      res_data = 1'b0;
      res_last = 1'b0;
    end else if (s1_cmd && (s1_idx == 2'd1)) begin
      res_byte = CMD_SET_Y | {2'b00, 6'(s1_page)};
      res_data = 1'b0;
      res_last = 1'b0;
    end
  end

  assign pix.ready = !s1_valid || s1_done;

  // Column memory
  rlpp_col_store u_store (
    .clk   (clk),
    .we    (s1_done && s1_we),
    .waddr (s1_col),
    .wdata (s1_wdata),
    .re    (accept),
    .raddr (col_cur),
    .rdata (rd_data)
  );

  // Counters and stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_in_page  <= '0;
      page_count   <= '0;
      s1_valid     <= 1'b0;
      s1_idx       <= '0;
      lcd.valid    <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        row_in_page  <= row_in_page_next;
        page_count   <= page_count_next;
        s1_valid     <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        s1_idx <= (s1_idx == last_idx) ? 2'd0 : s1_idx + 2'd1;
      end

      if (s1_move) begin
        lcd.valid <= 1'b1;
      end else if (lcd.ready) begin
        lcd.valid <= 1'b0;
      end
    end
  end

  // Second stage payload and forwarding of a same-column write
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col_cur;
      s1_row   <= row_cur;
      s1_page  <= page_cur;
      s1_lit   <= (pix.pixel_value != 16'd0);
      s1_emit  <= in_page && (row_cur == ROW_W'(7));
      s1_cmd   <= in_page && (row_cur == ROW_W'(7)) && (col_cur == '0);
      s1_we    <= in_page && (row_cur != ROW_W'(7));
      fwd      <= s1_done && s1_we && (s1_col == col_cur);
      fwd_data <= s1_wdata;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s1_move) begin
      lcd.out_byte <= res_byte;
      lcd.is_data  <= res_data;
      lcd.run_last <= res_last;
    end
  end

endmodule : raster_to_lcd_page_packer

`default_nettype wire

### rtl/core/rlpp_col_store.sv
`default_nettype none

// Per-column store of rows 0 to 6 of the page: one write port, one
// registered read port.
module rlpp_col_store
  import rlpp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [COL_W-1:0]  waddr,
  input  wire logic [BITS_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [COL_W-1:0]  raddr,
  output logic      [BITS_W-1:0] rdata
);

  logic [BITS_W-1:0] mem [DISPLAY_WIDTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : rlpp_col_store

`default_nettype wire

### tb/lcd_page_stream_checker.sv
`default_nettype none

// Watches the pixel and LCD byte channels, predicts every byte the packer
// must send and compares each LCD transfer with the oldest prediction.
module lcd_page_stream_checker
  import rlpp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  rlpp_pix_if       pix,
  rlpp_lcd_if       lcd,
  output int        fail_count,
  output int        pending_count,
  output int        bytes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       run_last;
  } lcd_byte_t;

  // Predictor state: rows 0 to 6 of the page per column, plus raster position
  logic [BITS_W-1:0] column_store [DISPLAY_WIDTH];
  logic [COL_W-1:0]  col_pos;
  logic [ROW_W-1:0]  row_pos;
  logic [PAGE_W-1:0] page_pos;
  lcd_byte_t         expected_bytes [$];

  // Fold one pixel into the page and queue the bytes it releases
  task automatic pack_pixel(input logic [15:0] value, input logic fs);
    logic lit;
    int   c;
    int   next_row;
    int   next_page;
    lit = |value;
    if (fs) begin
      col_pos  = '0;
      row_pos  = '0;
      page_pos = '0;
    end
    c = int'(col_pos);
    if (c >= DISPLAY_WIDTH) c = 0;

    if (int'(page_pos) < FULL_PAGES) begin
      if (row_pos == 0) begin
        column_store[c] = BITS_W'(lit);
      end else if (row_pos < 7) begin
        column_store[c] = column_store[c] | (BITS_W'(lit) << row_pos);
      end else begin
        // column 0 of the last row opens the page with both addresses
        if (c == 0) begin
          expected_bytes.push_back('{CMD_SET_X, 1'b0, 1'b0});
          expected_bytes.push_back('{CMD_SET_Y | (8'(page_pos) & 8'h3F), 1'b0, 1'b0});
        end
        expected_bytes.push_back('{{lit, column_store[c]}, 1'b1, 1'b1});
      end
    end

    // Raster position; wraps to a new frame after the tail rows, if any
    if (int'(col_pos) + 1 < DISPLAY_WIDTH) begin
      col_pos = col_pos + 1'b1;
    end else begin
      col_pos   = '0;
      next_row  = int'(row_pos) + 1;
      next_page = int'(page_pos);
      if (next_page < FULL_PAGES) begin
        if (next_row >= 8) begin
          next_row  = 0;
          next_page = next_page + 1;
          if (next_page >= FULL_PAGES && TAIL_ROWS == 0) next_page = 0;
        end
      end else if (next_row >= TAIL_ROWS) begin
        next_row  = 0;
        next_page = 0;
      end
      row_pos  = ROW_W'(next_row);
      page_pos = PAGE_W'(next_page);
    end
  endtask

  function automatic bit field_ok(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Sample both channels at the edge that completes a transfer
  always @(posedge clk) begin : monitor
    lcd_byte_t want;
    bit        ok;
    if (rst) begin
      col_pos  = '0;
      row_pos  = '0;
      page_pos = '0;
      expected_bytes.delete();
    end else begin
      if (pix.valid && pix.ready) pack_pixel(pix.pixel_value, pix.frame_start);
      if (lcd.valid && lcd.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none, actual 0x%02h is_data %0b last %0b",
                   $time, lcd.out_byte, lcd.is_data, lcd.run_last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_bytes.pop_front();
          ok   = field_ok("out_byte", want.out_byte, lcd.out_byte);
          ok   = field_ok("is_data", 8'(want.is_data), 8'(lcd.is_data)) && ok;
          ok   = field_ok("run_last", 8'(want.run_last), 8'(lcd.run_last)) && ok;
          if (!ok) fail_count <= fail_count + 1;
        end
        bytes_checked <= bytes_checked + 1;
      end
    end
    pending_count <= expected_bytes.size();
  end

endmodule : lcd_page_stream_checker

`default_nettype wire

### tb/tb_raster_to_lcd_page_packer.sv
`default_nettype none

module tb_raster_to_lcd_page_packer;
  timeunit 1ns;
  timeprecision 1ps;
  import rlpp_pkg::*;

  localparam int PAGE_ROWS     = 8;
  localparam int MAX_WAIT      = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   bytes_checked;
  int   pixels_sent;
  int   restarts;
  int   idle_cycles;
  int   sender_calm;
  int   receiver_calm;

  rlpp_pix_if pix ();
  rlpp_lcd_if lcd ();

  raster_to_lcd_page_packer u_dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .lcd (lcd)
  );

  lcd_page_stream_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .pix           (pix),
    .lcd           (lcd),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .bytes_checked (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Wait before a transfer; now and then a stretch with no waiting at all
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(8, 40);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Mix of dark pixels, single lit bits and arbitrary values
  function automatic logic [15:0] random_pixel();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_pixel(input logic [15:0] value, input bit fs);
    int gap;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid       <= 1'b1;
    pix.pixel_value <= value;
    pix.frame_start <= fs;
    do @(posedge clk); while (!pix.ready);
    pixels_sent++;
    if (fs) restarts++;
  endtask

  // Whole rows of random pixels; optional frame start on the first, sporadic ones after
  task automatic send_rows(input int n_rows, input bit first_fs, input int restart_odds);
    bit fs;
    for (int r = 0; r < n_rows; r++) begin
      for (int c = 0; c < DISPLAY_WIDTH; c++) begin
        if (r == 0 && c == 0) fs = first_fs;
        else fs = (restart_odds > 0) && ($urandom_range(1, restart_odds) == 1);
        send_pixel(random_pixel(), fs);
      end
    end
  endtask

  // Hold the pixel side off until every predicted byte has gone out
  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // LCD side: after each transfer ready may drop for a random wait
  initial begin : lcd_receiver
    int hold;
    lcd.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = draw_wait(receiver_calm);
      if (hold > 0) begin
        lcd.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      lcd.ready <= 1'b1;
      do @(posedge clk); while (!lcd.valid);
    end
  end

  // Give up when neither channel has moved for too long
  always @(posedge clk) begin : watchdog
    if (rst || (pix.valid && pix.ready) || (lcd.valid && lcd.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles, %0d bytes outstanding",
               $time, idle_cycles, pending_count);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    rst             <= 1'b1;
    pix.valid       <= 1'b0;
    pix.pixel_value <= '0;
    pix.frame_start <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Field extremes and walking bits along row 0
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h8000, 1'b0);
    for (int k = 0; k < 16; k++) send_pixel(16'h0001 << k, 1'b0);
    // restart mid-row, then a second restart right after it
    send_pixel(16'h7FFF, 1'b1);
    send_pixel(16'h0000, 1'b1);

    // One whole page from a frame start, then let the byte side run dry
    send_rows(PAGE_ROWS, 1'b1, 0);
    drain();

    $display("Covered %0d pixels: row 0 extremes, %0d frame starts and a full page;",
             pixels_sent, restarts);
    $display("%0d LCD bytes compared, with random stalls on both channels.", bytes_checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : tb_raster_to_lcd_page_packer

`default_nettype wire

### raster_to_lcd_page_packer.f
rtl/core/rlpp_pkg.sv
rtl/core/rlpp_if.sv
rtl/core/rlpp_col_store.sv
rtl/core/raster_to_lcd_page_packer.sv
tb/lcd_page_stream_checker.sv
tb/tb_raster_to_lcd_page_packer.sv
